### rtl/uart_receiver_with_fifo_unit_assert.svh
// Assertion macros used by the receiver FIFO.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef UART_RECEIVER_WITH_FIFO_UNIT_ASSERT_SVH
`define UART_RECEIVER_WITH_FIFO_UNIT_ASSERT_SVH

// Same-cycle implication.
`define URF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("urf assertion failed");

// Next-cycle implication.
`define URF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("urf assertion failed");

`endif

### rtl/urf_pkg.sv
package urf_pkg;

    // Frame progress codes held in the bit phase counter.
    localparam logic [3:0] PHASE_FRAME_START = 4'd10;
    localparam logic [3:0] PHASE_START_BIT   = 4'd9;
    localparam logic [3:0] PHASE_STOP_BIT    = 4'd0;

    localparam logic [15:0] BIT_PERIOD_RESET = 16'd868;

    // Configuration port geometry.
    localparam int          APB_AW         = 3;
    localparam logic        REG_BIT_PERIOD = 1'b0;

    // Byte leaving the bit sampler at the end of a good frame.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } push_t;

endpackage

### rtl/urf_rx_core.sv
module urf_rx_core
    import urf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic        line,
    input  logic [15:0] bit_period,
    output push_t       push
);

    logic        receiving_reg, receiving_next;
    logic        prev_line_reg, prev_line_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [3:0]  bit_phase_reg, bit_phase_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [3:0]  phase_dec;

    assign phase_dec = bit_phase_reg - 4'd1;

    always_comb
    begin
        receiving_next  = receiving_reg;
        prev_line_next  = prev_line_reg;
        tick_count_next = tick_count_reg;
        bit_phase_next  = bit_phase_reg;
        shift_byte_next = shift_byte_reg;
        push.valid      = 1'b0;
        push.data       = shift_byte_reg;
        if (step)
        begin
            prev_line_next = line;
            if (!receiving_reg)
            begin
                // A falling edge opens a frame; first sample lands mid start bit.
                if (prev_line_reg && !line)
                begin
                    receiving_next  = 1'b1;
                    tick_count_next = {1'b0, bit_period[15:1]};
                    bit_phase_next  = PHASE_FRAME_START;
                end
            end
            else if (tick_count_reg <= 16'd1)
            begin
                tick_count_next = bit_period;
                bit_phase_next  = phase_dec;
                if (phase_dec == PHASE_START_BIT)
                begin
                    if (line)
                    begin
                        receiving_next = 1'b0;
                    end
                end
                else if (phase_dec == PHASE_STOP_BIT)
                begin
                    push.valid     = line;
                    receiving_next = 1'b0;
                end
                else
                begin
                    shift_byte_next = {line, shift_byte_reg[7:1]};
                end
            end
            else
            begin
                tick_count_next = tick_count_reg - 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg  <= 1'b0;
            prev_line_reg  <= 1'b1;
            tick_count_reg <= 16'd0;
            bit_phase_reg  <= 4'd0;
            shift_byte_reg <= 8'd0;
        end
        else
        begin
            receiving_reg  <= receiving_next;
            prev_line_reg  <= prev_line_next;
            tick_count_reg <= tick_count_next;
            bit_phase_reg  <= bit_phase_next;
            shift_byte_reg <= shift_byte_next;
        end
    end

endmodule

### rtl/urf_fifo.sv
module urf_fifo
    import urf_pkg::*;
#(
    parameter int FIFO_DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       pop_req,
    input  push_t      push,
    output logic [7:0] read_data,
    output logic       read_valid,
    output logic       not_empty
);

`include "uart_receiver_with_fifo_unit_assert.svh"

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [PW-1:0] LAST_SLOT = PW'(FIFO_DEPTH - 1);

    logic [7:0]    mem [FIFO_DEPTH];
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_inc, wr_inc;
    logic          pop_ok, push_ok;
    logic [7:0]    read_data_reg;
    logic          read_valid_reg, not_empty_reg;

    assign rd_inc = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
    assign wr_inc = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;

    // Both decisions look at the pointers from the start of the tick.
    assign pop_ok  = step && pop_req && (rd_ptr_reg != wr_ptr_reg);
    assign push_ok = step && push.valid && (wr_inc != rd_ptr_reg);

    assign rd_ptr_next = pop_ok ? rd_inc : rd_ptr_reg;
    assign wr_ptr_next = push_ok ? wr_inc : wr_ptr_reg;

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[wr_ptr_reg] <= push.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            read_data_reg  <= 8'd0;
            read_valid_reg <= 1'b0;
            not_empty_reg  <= 1'b0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            if (step)
            begin
                read_data_reg  <= pop_ok ? mem[rd_ptr_reg] : 8'd0;
                read_valid_reg <= pop_ok;
                not_empty_reg  <= (rd_ptr_next != wr_ptr_next);
            end
        end
    end

    assign read_data  = read_data_reg;
    assign read_valid = read_valid_reg;
    assign not_empty  = not_empty_reg;

    `URF_ASSERT_IMP(a_idle_data_zero, !read_valid_reg, read_data_reg == 8'd0)
    `URF_ASSERT_NEXT(a_push_not_empty, push_ok, not_empty_reg)
    `URF_ASSERT_NEXT(a_ptrs_hold, !step, $stable(rd_ptr_reg) && $stable(wr_ptr_reg))
    `URF_ASSERT_NEXT(a_pop_shows, pop_ok, read_valid_reg)

endmodule

### rtl/uart_receiver_with_fifo_unit.sv
// 8N1 serial receiver with a receive FIFO.
// The slave stream carries one clock tick of the serial line per beat:
// s_tdata[0] is the line level and s_tdata[1] asks to pop the oldest byte.
// Every accepted beat yields exactly one master beat in the next cycle:
// m_tdata[7:0] is the popped byte (zero if none), m_tdata[8] flags a
// successful pop, and m_tdata[9] says bytes are still waiting.
// Throughput is one beat per cycle unless the master stalls; the bit timer,
// the sampler and the FIFO pointers all update in the single cycle that
// accepts the beat; the FIFO read port feeds the result register directly.
// Bit timing counts accepted beats, not clocks, so the serial rate is
// bit_period beats per bit. bit_period sits at APB byte address 0 and resets
// to 868; it may only be rewritten while the stream is quiet.
// Reset returns the receiver to idle with an empty FIFO and the line taken
// as high; the FIFO contents themselves are not cleared.
// If the master side stalls, the result register holds its beat and
// s_tready falls, so no tick is lost or counted while stalled.
// The FIFO holds FIFO_DEPTH-1 bytes; a byte that arrives while it is full
// is dropped, and a frame with a low stop bit is discarded.
module uart_receiver_with_fifo_unit
    import urf_pkg::*;
#(
    parameter int FIFO_DEPTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    // Slave stream.
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [0] rx_line, [1] pop_req, rest zero
    // Master stream.
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [7:0] read_data, [8] read_valid,
                                         // [9] fifo_not_empty, rest zero
    // APB configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic        out_valid_reg;
    logic        step;
    logic [15:0] bit_period_reg;
    push_t       push;
    logic [7:0]  read_data;
    logic        read_valid;
    logic        not_empty;

    // The output register frees itself when the master takes its beat,
    // so a new tick can enter in the same cycle.
    assign s_tready = !out_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, not_empty, read_valid, read_data};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Register file: one register, decoded on the word address bit.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BIT_PERIOD) ? {16'd0, bit_period_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= BIT_PERIOD_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_BIT_PERIOD))
        begin
            bit_period_reg <= pwdata[15:0];
        end
    end

    urf_rx_core u_rx_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .line       (s_tdata[0]),
        .bit_period (bit_period_reg),
        .push       (push)
    );

    urf_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .pop_req    (s_tdata[1]),
        .push       (push),
        .read_data  (read_data),
        .read_valid (read_valid),
        .not_empty  (not_empty)
    );

endmodule
